### hw/rtl/escaped_run_length_encoder_top_assert.svh
// assertion macros for the escaped run-length encoder
// used by modules that check their own logic, no other dependencies
`ifndef ESCAPED_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH
`define ESCAPED_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ERLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("erle check failed");

// next-cycle implication, checked outside reset
`define ERLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("erle check failed");

`endif

### hw/rtl/erle_pkg.sv
// shared types, constants and helper functions of the escaped run-length encoder
// no dependencies
package erle_pkg;

    localparam logic [7:0] ESCAPE_BYTE   = 8'd1;
    localparam logic [7:0] MIN_PACKED    = 8'd4;
    localparam logic [7:0] RESET_MAX_RUN = 8'd100;

    localparam logic [1:0] SLOT_ESCAPE = 2'd0;
    localparam logic [1:0] SLOT_VALUE  = 2'd1;

    // one queued item: up to two run flushes and the end mark
    typedef struct packed {
        logic [7:0] value_a;
        logic [7:0] len_a;
        logic [7:0] value_b;
        logic [7:0] len_b;
        logic       end_flag;
        logic [2:0] n_out;
    } erle_job_t;

    // bytes produced by flushing a run of this length
    function automatic logic [2:0] run_outputs(input logic [7:0] len);
        logic [2:0] n;
        if (len >= MIN_PACKED)
            n = 3'd3;
        else
            n = len[2:0];
        return n;
    endfunction

    // byte at slot idx of a flushed run
    function automatic logic [7:0] run_byte(input logic [7:0] value,
                                            input logic [7:0] len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        if (len >= MIN_PACKED)
        begin
            unique case (idx)
                SLOT_ESCAPE: b = ESCAPE_BYTE;
                SLOT_VALUE:  b = value;
                default:     b = len;
            endcase
        end
        else
            b = value;
        return b;
    endfunction

endpackage

### hw/rtl/erle_front.sv
// front stage: accepts text bytes, tracks the pending run, builds flush jobs
// depends on erle_pkg
module erle_front
    import erle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       push,
    output erle_job_t  push_data,
    input  logic       q_full
);

    logic [7:0] max_run_reg, max_run_next;
    logic [7:0] run_value_reg, run_value_next;
    logic [7:0] run_len_reg, run_len_next;
    logic [7:0] limit;
    logic [7:0] cur_value;
    logic [7:0] cur_len;
    logic       accept;
    logic       extend;
    erle_job_t  job;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign limit    = (max_run_reg < MIN_PACKED) ? MIN_PACKED : max_run_reg;
    assign extend   = (run_len_reg != 8'd0) && (in_byte == run_value_reg)
                      && (run_len_reg < limit);

    always_comb
    begin
        job       = '0;
        cur_value = in_byte;
        cur_len   = 8'd1;
        if (extend)
        begin
            cur_value = run_value_reg;
            cur_len   = run_len_reg + 8'd1;
        end
        else
        begin
            job.value_a = run_value_reg;
            job.len_a   = run_len_reg;
        end
        if (end_of_text)
        begin
            job.value_b = cur_value;
            job.len_b   = cur_len;
        end
        job.end_flag = end_of_text;
        job.n_out    = run_outputs(job.len_a) + run_outputs(job.len_b);
    end

    assign push      = accept && (job.n_out != 3'd0);
    assign push_data = job;

    always_comb
    begin
        max_run_next   = cfg_wr_en ? cfg_wr_data : max_run_reg;
        run_value_next = run_value_reg;
        run_len_next   = run_len_reg;
        if (accept)
        begin
            run_value_next = cur_value;
            run_len_next   = end_of_text ? 8'd0 : cur_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg   <= RESET_MAX_RUN;
            run_value_reg <= 8'd0;
            run_len_reg   <= 8'd0;
        end
        else
        begin
            max_run_reg   <= max_run_next;
            run_value_reg <= run_value_next;
            run_len_reg   <= run_len_next;
        end
    end

endmodule

### hw/rtl/erle_queue.sv
// short job queue between front and back stages
// depends on erle_pkg
module erle_queue
    import erle_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  erle_job_t push_data,
    output logic      full,
    input  logic      pop,
    output erle_job_t pop_data,
    output logic      q_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    erle_job_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign q_valid  = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        if (push && !pop)
            count_next = count_reg + CNT_ONE;
        else if (pop && !push)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/erle_back.sv
// back stage: expands one job into its output bytes, one per cycle while out_stall is low
// depends on erle_pkg and the assertion macro header
module erle_back
    import erle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  erle_job_t  q_data,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_for_input,
    output logic       end_of_code
);

`include "escaped_run_length_encoder_top_assert.svh"

    erle_job_t  cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       eoc_reg;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic       load;
    logic [2:0] cnt_a;
    logic [7:0] sel_byte;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = out_free && cur_valid_reg;
    assign is_last  = ({1'b0, pos_reg} == (cur_reg.n_out - 3'd1));
    assign load     = !cur_valid_reg || (emit && is_last);
    assign pop      = load && q_valid;
    assign cnt_a    = run_outputs(cur_reg.len_a);

    always_comb
    begin
        if ({1'b0, pos_reg} < cnt_a)
            sel_byte = run_byte(cur_reg.value_a, cur_reg.len_a, pos_reg);
        else
            sel_byte = run_byte(cur_reg.value_b, cur_reg.len_b, pos_reg - cnt_a[1:0]);
    end

    always_comb
    begin
        out_valid_next = out_free ? emit : out_valid_reg;
        cur_valid_next = load ? q_valid : cur_valid_reg;
        pos_next       = pop ? 2'd0 : (emit ? pos_reg + 2'd1 : pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_data;
        if (emit)
        begin
            out_byte_reg <= sel_byte;
            last_reg     <= is_last;
            eoc_reg      <= is_last && cur_reg.end_flag;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign last_for_input = last_reg;
    assign end_of_code    = eoc_reg;

    `ERLE_ASSERT_NOW(a_pos_in_job, clk, rst_n, cur_valid_reg, {1'b0, pos_reg} < cur_reg.n_out)
    `ERLE_ASSERT_NOW(a_job_not_empty, clk, rst_n, pop, q_data.n_out != 3'd0)
    `ERLE_ASSERT_NOW(a_end_is_last, clk, rst_n, out_valid_reg && eoc_reg, last_reg)
    `ERLE_ASSERT_NEXT(a_mid_job_busy, clk, rst_n, emit && !is_last, cur_valid_reg)

endmodule

### hw/rtl/escaped_run_length_encoder_top.sv
// escaped run-length encoder, top level: front stage, job queue, back stage
// depends on erle_pkg, erle_front, erle_queue, erle_back
//
// One text byte is taken per cycle while in_stall is low. Each item yields
// zero to four encoded bytes (a literal, or escape 1, run byte and count),
// delivered by the back stage from its output register, one per cycle while
// out_stall is low. The front keeps accepting while the QUEUE_DEPTH-entry
// job queue has room; in_stall rises only when it is full. With the back
// stage idle, an accepted item passes through the job queue and the back
// stage's job register before out_valid rises with its first byte.
module escaped_run_length_encoder_top
    import erle_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_for_input,
    output logic       end_of_code
);

    logic      push;
    erle_job_t push_data;
    logic      q_full;
    logic      pop;
    erle_job_t pop_data;
    logic      q_valid;

    erle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    erle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_valid   (q_valid)
    );

    erle_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (pop_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_for_input (last_for_input),
        .end_of_code    (end_of_code)
    );

endmodule

### bench/tb.sv
// testbench for escaped_run_length_encoder_top: directed and random texts,
// results checked in order against an in-bench model of the run encoding
// depends on erle_pkg and the encoder rtl
module tb;
    import erle_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOWN_ERRORS  = 10;
    localparam int PHASE_ITEMS   = 24;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       eoc;
    } code_byte_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_text;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_for_input;
    logic       end_of_code;

    logic [7:0] max_run_cfg;
    logic [7:0] run_val;
    logic [7:0] run_cnt;
    code_byte_t code_due[$];
    code_byte_t step_codes[$];
    code_byte_t want;
    code_byte_t got;

    int fail_count  = 0;
    int sent_count  = 0;
    int cycle_count = 0;
    int in_gap_max  = 0;
    int stall_max   = 0;

    escaped_run_length_encoder_top uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_for_input (last_for_input),
        .end_of_code    (end_of_code)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic void put_code(input logic [7:0] b);
        step_codes.push_back(code_byte_t'({b, 2'b00}));
    endfunction

    function automatic void flush_run();
        if (run_cnt >= MIN_PACKED)
        begin
            put_code(ESCAPE_BYTE);
            put_code(run_val);
            put_code(run_cnt);
        end
        else
        begin
            for (int i = 0; i < run_cnt; i++)
                put_code(run_val);
        end
        run_cnt = 8'd0;
    endfunction

    // expected encoded bytes for one accepted text byte
    function automatic void encode_text_byte(input logic [7:0] b, input logic eot);
        logic [7:0] limit;
        code_byte_t tail;
        limit = (max_run_cfg < MIN_PACKED) ? MIN_PACKED : max_run_cfg;
        step_codes.delete();
        if (run_cnt != 0 && b == run_val)
        begin
            if (run_cnt >= limit)
            begin
                flush_run();
                run_val = b;
                run_cnt = 8'd1;
            end
            else
                run_cnt = run_cnt + 8'd1;
        end
        else
        begin
            flush_run();
            run_val = b;
            run_cnt = 8'd1;
        end
        if (eot)
            flush_run();
        if (step_codes.size() > 0)
        begin
            tail = step_codes.pop_back();
            tail.last = 1'b1;
            tail.eoc = eot;
            step_codes.push_back(tail);
        end
        foreach (step_codes[i])
            code_due.push_back(step_codes[i]);
    endfunction

    // result check first, then prediction of the item taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {out_byte, last_for_input, end_of_code};
                if (code_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                        $display("unexpected result: byte %02h last %0b end %0b",
                                 out_byte, last_for_input, end_of_code);
                end
                else
                begin
                    want = code_due.pop_front();
                    if (want != got)
                    begin
                        fail_count++;
                        if (fail_count <= SHOWN_ERRORS)
                            $display("mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                     want.code, want.last, want.eoc,
                                     got.code, got.last, got.eoc);
                    end
                end
            end
            if (in_valid && !in_stall)
                encode_text_byte(in_byte, end_of_text);
        end
    end

    // output side: random stall before each result
    initial
    begin
        int w;
        out_stall = 1'b0;
        forever
        begin
            w = $urandom_range(0, stall_max);
            repeat (w)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rst_n && out_valid));
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eot);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    task automatic drain_codes(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (code_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_max_run(input logic [7:0] v);
        drain_codes(SETTLE_CYCLES);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        max_run_cfg = v;
    endtask

    // plain literals, escape value as literal, short runs, four results on one item
    task automatic test_literals;
        in_gap_max = 0;
        stall_max = 0;
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(ESCAPE_BYTE, 1'b0);
        send_item(ESCAPE_BYTE, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b1);
    endtask

    task automatic test_escape_run;
        repeat (3) send_item(8'h7E, 1'b0);
        send_item(8'h7E, 1'b1);
    endtask

    // max_run below the minimum acts as four
    task automatic test_small_max_run;
        set_max_run(8'd0);
        in_gap_max = 5;
        stall_max = 5;
        repeat (4) send_item(8'h33, 1'b0);
        send_item(8'h33, 1'b1);
    endtask

    // limit lowered while a longer run is pending
    task automatic test_max_run_lowered;
        set_max_run(8'd255);
        repeat (6) send_item(8'h42, 1'b0);
        set_max_run(MIN_PACKED);
        send_item(8'h42, 1'b0);
        send_item(8'h42, 1'b1);
    endtask

    task automatic send_text;
        int n_runs;
        int len;
        int pick;
        int cap;
        logic [7:0] val;
        logic [7:0] limit;
        limit = (max_run_cfg < MIN_PACKED) ? MIN_PACKED : max_run_cfg;
        cap = (limit > 20) ? 20 : int'(limit);
        n_runs = $urandom_range(1, 5);
        val = 8'($urandom);
        for (int r = 0; r < n_runs; r++)
        begin
            if ($urandom_range(0, 3) != 0)
                val = 8'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                len = $urandom_range(1, 3);
            else if (pick < 9)
                len = $urandom_range(4, cap);
            else if (limit > 20)
                len = $urandom_range(1, 5);
            else
                len = int'(limit) + $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_item(val, (r == n_runs - 1) && (i == len - 1));
        end
    endtask

    task automatic test_random_texts;
        int target;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_max_run(8'd255);
                1: set_max_run(MIN_PACKED);
                2: set_max_run(8'($urandom_range(0, 3)));
                3: set_max_run(8'($urandom_range(5, 16)));
                4: set_max_run(8'($urandom_range(4, 255)));
                default: set_max_run(RESET_MAX_RUN);
            endcase
            in_gap_max = (p == 0 || p == 2) ? 0 : 5;
            stall_max = (p == 0 || p == 1) ? 0 : 5;
            target = sent_count + PHASE_ITEMS;
            while (sent_count < target)
            begin
                send_text();
                if ($urandom_range(0, 3) == 0)
                    drain_codes(0);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'd0;
        in_valid = 1'b0;
        in_byte = 8'd0;
        end_of_text = 1'b0;
        max_run_cfg = RESET_MAX_RUN;
        run_val = 8'd0;
        run_cnt = 8'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_literals();
        test_escape_run();
        test_small_max_run();
        test_max_run_lowered();
        test_random_texts();

        drain_codes(SETTLE_CYCLES);
        if (fail_count == 0 && code_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
